// File: rtl/bof_pkg.sv
// ---------------------------------------------------------------------------
// bof_pkg
// Shared types, constants and the crc-32 byte update for the report framer.
// ---------------------------------------------------------------------------
package bof_pkg;

    localparam int FRAME_LEN        = 74;
    localparam int MIN_WIRELESS_LEN = 15;
    localparam int MAX_RESULTS      = 64;
    localparam int PAD_ROOM         = MAX_RESULTS - 4;

    localparam logic [31:0] CRC_POLY      = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT      = 32'hFFFFFFFF;
    localparam logic [7:0]  CRC_SEED_BYTE = 8'hA2;

    localparam logic [7:0] ID_OLD_PAD  = 8'h05;
    localparam logic [7:0] ID_NEW_PAD  = 8'h02;
    localparam logic [7:0] HDR_OLD_B0  = 8'h11;
    localparam logic [7:0] HDR_OLD_B1  = 8'hC0;
    localparam logic [7:0] HDR_OLD_B2  = 8'h00;
    localparam logic [7:0] HDR_NEW_B0  = 8'h31;
    localparam logic [7:0] HDR_NEW_B2  = 8'h10;

    // configuration register indexes
    localparam logic [1:0] REG_WIRELESS = 2'd0;
    localparam logic [1:0] REG_KIND     = 2'd1;
    localparam logic [1:0] REG_MAX_LEN  = 2'd2;

    // header rewrite kinds
    localparam logic [1:0] HDR_NONE = 2'd0;
    localparam logic [1:0] HDR_OLD  = 2'd1;
    localparam logic [1:0] HDR_NEW  = 2'd2;

    typedef struct packed {
        logic       accept;
        logic       pass;
        logic       frame;
        logic       pad_load;
        logic       pad;
        logic       crc;
        logic       finish;
        logic [1:0] step;
    } cmd_t;

    typedef struct packed {
        logic drop;
        logic wireless;
        logic hdr_multi;
        logic last;
        logic pad_zero;
        logic out_free;
    } status_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                             input logic [7:0]  data);
        logic [31:0] c;
        c = crc_in ^ {24'd0, data};
        for (int i = 0; i < 8; i++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

    localparam logic [31:0] CRC_SEEDED = crc_byte(CRC_INIT, CRC_SEED_BYTE);

endpackage

// File: rtl/bof_ctrl.sv
// ---------------------------------------------------------------------------
// bof_ctrl
// Sequencer for the report framer: steps one input byte through pass,
// header, padding and crc phases, one output transaction at a time.
// ---------------------------------------------------------------------------
module bof_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  bof_pkg::status_t status,
    output bof_pkg::cmd_t    cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DISP = 3'd1;
    localparam logic [2:0] S_PASS = 3'd2;
    localparam logic [2:0] S_BODY = 3'd3;
    localparam logic [2:0] S_PLD  = 3'd4;
    localparam logic [2:0] S_PAD  = 3'd5;
    localparam logic [2:0] S_CRC  = 3'd6;
    localparam logic [2:0] S_END  = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic [1:0] step_reg;
    logic [1:0] step_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        cmd.step   = step_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                step_next = 2'd0;
                if (status.drop)
                    state_next = S_END;
                else if (!status.wireless)
                    state_next = S_PASS;
                else
                    state_next = S_BODY;
            end
            S_PASS:
            begin
                if (status.out_free)
                begin
                    cmd.pass   = 1'b1;
                    state_next = S_END;
                end
            end
            S_BODY:
            begin
                if (status.out_free)
                begin
                    cmd.frame = 1'b1;
                    if (status.hdr_multi && step_reg != 2'd2)
                        step_next = step_reg + 2'd1;
                    else if (status.last)
                        state_next = S_PLD;
                    else
                        state_next = S_END;
                end
            end
            S_PLD:
            begin
                cmd.pad_load = 1'b1;
                state_next   = S_PAD;
            end
            S_PAD:
            begin
                step_next = 2'd0;
                if (status.pad_zero)
                    state_next = S_CRC;
                else if (status.out_free)
                    cmd.pad = 1'b1;
            end
            S_CRC:
            begin
                if (status.out_free)
                begin
                    cmd.crc   = 1'b1;
                    step_next = step_reg + 2'd1;
                    if (step_reg == 2'd3)
                        state_next = S_END;
                end
            end
            S_END:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/bof_datapath.sv
// ---------------------------------------------------------------------------
// bof_datapath
// Report framer datapath: configuration registers, report state, header
// rewrite, crc-32 accumulator, padding counter and output register.
// ---------------------------------------------------------------------------
module bof_datapath
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    input  logic [1:0]       cfg_addr,
    input  logic [15:0]      cfg_data,
    input  logic [23:0]      s_tdata,
    input  logic             s_tlast,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata,
    output logic             m_tlast,
    input  bof_pkg::cmd_t    cmd,
    output bof_pkg::status_t status
);

    logic        wireless_reg;
    logic        kind_reg;
    logic [15:0] max_len_reg;

    logic [3:0]  seq_reg;
    logic [31:0] crc_reg;
    logic [6:0]  fpos_reg;
    logic        drop_reg;
    logic [15:0] bidx_reg;
    logic [1:0]  res_cnt_reg;
    logic [6:0]  pad_cnt_reg;

    logic [7:0]  byte_reg;
    logic        last_reg;
    logic        first_reg;

    logic        out_valid_reg;
    logic [7:0]  out_byte_reg;
    logic        out_end_reg;

    logic [7:0]  in_byte;
    logic [15:0] in_len;
    logic        in_first;
    logic        drop_next;
    logic [1:0]  hdr_kind;
    logic [7:0]  frame_byte;
    logic        frame_room;
    logic        put_frame;
    logic [7:0]  put_byte;
    logic [31:0] crc_out;
    logic [7:0]  crc_sel;
    logic [6:0]  pad_remain;
    logic [6:0]  pad_room;
    logic        out_free;

    assign in_byte  = s_tdata[7:0];
    assign in_len   = s_tdata[23:8];
    assign in_first = (bidx_reg == 16'd0);
    assign drop_next = (in_len > max_len_reg) ||
                       (wireless_reg &&
                        in_len < 16'(bof_pkg::MIN_WIRELESS_LEN));

    always_comb
    begin
        hdr_kind = bof_pkg::HDR_NONE;
        if (first_reg && !kind_reg && byte_reg == bof_pkg::ID_OLD_PAD)
            hdr_kind = bof_pkg::HDR_OLD;
        else if (first_reg && kind_reg && byte_reg == bof_pkg::ID_NEW_PAD)
            hdr_kind = bof_pkg::HDR_NEW;
    end

    always_comb
    begin
        frame_byte = byte_reg;
        if (hdr_kind == bof_pkg::HDR_OLD)
        begin
            case (cmd.step)
                2'd0:    frame_byte = bof_pkg::HDR_OLD_B0;
                2'd1:    frame_byte = bof_pkg::HDR_OLD_B1;
                default: frame_byte = bof_pkg::HDR_OLD_B2;
            endcase
        end
        else if (hdr_kind == bof_pkg::HDR_NEW)
        begin
            case (cmd.step)
                2'd0:    frame_byte = bof_pkg::HDR_NEW_B0;
                2'd1:    frame_byte = {seq_reg, 4'd0};
                default: frame_byte = bof_pkg::HDR_NEW_B2;
            endcase
        end
    end

    // frame bytes beyond the frame length are swallowed
    assign frame_room = (fpos_reg < 7'(bof_pkg::FRAME_LEN));
    assign put_frame  = (cmd.frame || cmd.pad) && frame_room;
    assign put_byte   = cmd.pad ? 8'h00 : frame_byte;

    assign crc_out = ~crc_reg;
    always_comb
    begin
        case (cmd.step)
            2'd0:    crc_sel = crc_out[7:0];
            2'd1:    crc_sel = crc_out[15:8];
            2'd2:    crc_sel = crc_out[23:16];
            default: crc_sel = crc_out[31:24];
        endcase
    end

    assign pad_remain = 7'(bof_pkg::FRAME_LEN) - fpos_reg;
    assign pad_room   = 7'(bof_pkg::PAD_ROOM) - {5'd0, res_cnt_reg};

    assign out_free = !out_valid_reg || m_tready;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wireless_reg <= 1'b0;
            kind_reg     <= 1'b0;
            max_len_reg  <= 16'd78;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_addr)
                bof_pkg::REG_WIRELESS: wireless_reg <= cfg_data[0];
                bof_pkg::REG_KIND:     kind_reg     <= cfg_data[0];
                bof_pkg::REG_MAX_LEN:  max_len_reg  <= cfg_data;
                default:               ;
            endcase
        end
    end

    // item holding registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            byte_reg  <= in_byte;
            last_reg  <= s_tlast;
            first_reg <= in_first;
        end
    end

    // report state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg     <= 4'd0;
            crc_reg     <= bof_pkg::CRC_INIT;
            fpos_reg    <= 7'd0;
            drop_reg    <= 1'b0;
            bidx_reg    <= 16'd0;
            res_cnt_reg <= 2'd0;
            pad_cnt_reg <= 7'd0;
        end
        else
        begin
            if (cmd.accept)
            begin
                if (in_first)
                begin
                    drop_reg <= drop_next;
                    if (wireless_reg)
                    begin
                        crc_reg  <= bof_pkg::CRC_SEEDED;
                        fpos_reg <= 7'd0;
                    end
                end
                if (s_tlast)
                    bidx_reg <= 16'd0;
                else if (bidx_reg != 16'hFFFF)
                    bidx_reg <= bidx_reg + 16'd1;
            end
            if (put_frame)
            begin
                crc_reg  <= bof_pkg::crc_byte(crc_reg, put_byte);
                fpos_reg <= fpos_reg + 7'd1;
            end
            if (cmd.frame && frame_room)
                res_cnt_reg <= res_cnt_reg + 2'd1;
            if (cmd.frame && hdr_kind == bof_pkg::HDR_NEW && cmd.step == 2'd2)
                seq_reg <= seq_reg + 4'd1;
            if (cmd.pad_load)
                pad_cnt_reg <= (pad_remain < pad_room) ? pad_remain : pad_room;
            else if (cmd.pad)
                pad_cnt_reg <= pad_cnt_reg - 7'd1;
            if (cmd.finish)
            begin
                res_cnt_reg <= 2'd0;
                if (last_reg)
                begin
                    drop_reg <= 1'b0;
                    fpos_reg <= 7'd0;
                    crc_reg  <= bof_pkg::CRC_INIT;
                end
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.pass || put_frame || cmd.crc)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.pass)
        begin
            out_byte_reg <= byte_reg;
            out_end_reg  <= last_reg;
        end
        else if (put_frame)
        begin
            out_byte_reg <= put_byte;
            out_end_reg  <= 1'b0;
        end
        else if (cmd.crc)
        begin
            out_byte_reg <= crc_sel;
            out_end_reg  <= (cmd.step == 2'd3);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_end_reg;

    assign status.drop      = drop_reg;
    assign status.wireless  = wireless_reg;
    assign status.hdr_multi = (hdr_kind != bof_pkg::HDR_NONE);
    assign status.last      = last_reg;
    assign status.pad_zero  = (pad_cnt_reg == 7'd0);
    assign status.out_free  = out_free;

endmodule

// File: rtl/bt_output_report_framer.sv
// ---------------------------------------------------------------------------
// bt_output_report_framer
// Output report framer: pass-through or wireless framing with crc-32 trailer.
// ---------------------------------------------------------------------------
// sequencing: an input byte is accepted when idle, dispatched, then sent through
// the pass or body state (or dropped) and an end state. A rewritten header byte
// gives three output bytes, the last wireless byte padding and four crc bytes.
// Output holds for the sink; s_tready is high only when idle, so one byte at a time.
// reset: rst_n asynchronous, clears config (max length 78), sequence and crc.
module bt_output_report_framer
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // data_byte [7:0], report_len [23:8]
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // out_byte [7:0]
    output logic        m_tlast    // frame_end
);

    bof_pkg::cmd_t    cmd;
    bof_pkg::status_t status;

    assign cfg_ready = 1'b1;

    bof_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    bof_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

// File: bench/tb_bt_output_report_framer.sv
// ----------------------------------------------------------------------------
// tb_bt_output_report_framer
// Self-checking bench for the output report framer. Report bytes stream in
// through the slave side. A predictor of the framing, padding and crc-32 rules
// works out the bytes due on the master side, and each one that leaves is
// checked against them. The bench covers pass-through, both header rewrites,
// dropped reports and a frame overrun, with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_bt_output_report_framer;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int     DRAIN_CYCLES = 16;
    localparam int     IDLE_PCT     = 18;
    localparam longint LIMIT_CYCLES = 300_000;

    typedef struct packed {
        logic [7:0]  data;
        logic        last;
        logic [15:0] len;
    } report_byte_t;

    typedef struct packed {
        logic [7:0] data;
        logic       frame_end;
    } tx_byte_t;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_addr  = '0;
    logic [15:0] cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = '0;   // data_byte [7:0], report_len [23:8]
    logic        s_tlast   = 1'b0; // last_byte
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;          // out_byte [7:0]
    logic        m_tlast;          // frame_end

    bt_output_report_framer dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // predictor copy of the registers and the framing state
    logic        wl_mode   = 1'b0;
    logic        kind      = 1'b0;
    logic [15:0] max_len   = 16'd78;
    logic [3:0]  seq_num   = '0;
    logic [31:0] crc_acc   = bof_pkg::CRC_INIT;
    logic [6:0]  frame_pos = '0;
    logic        drop_rpt  = 1'b0;
    logic [15:0] byte_idx  = '0;
    int          step_count;

    report_byte_t report_bytes_q[$];
    tx_byte_t     tx_bytes_due[$];
    tx_byte_t     due_byte;
    report_byte_t next_byte;
    logic         in_fire = 1'b0;
    logic         calm    = 1'b0;
    int           items_queued = 0;
    int           fail_count   = 0;
    longint       cycle_count  = 0;

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic logic [31:0] crc32_update(input logic [31:0] crc_in,
                                                 input logic [7:0]  d);
        logic [31:0] c;
        logic        fb;
        c = crc_in;
        for (int i = 0; i < 8; i++)
        begin
            fb = c[0] ^ d[i];
            c  = c >> 1;
            if (fb)
                c = c ^ bof_pkg::CRC_POLY;
        end
        return c;
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at cycle %0d: %s", cycle_count, what);
        fail_count++;
    endtask

    task automatic push_tx(input logic [7:0] d, input logic fend);
        tx_byte_t tx;
        tx.data      = d;
        tx.frame_end = fend;
        if (step_count < bof_pkg::MAX_RESULTS)
        begin
            tx_bytes_due.insert(tx_bytes_due.size(), tx);
            step_count++;
        end
    endtask

    task automatic frame_byte(input logic [7:0] d);
        if (frame_pos < bof_pkg::FRAME_LEN)
        begin
            push_tx(d, 1'b0);
            crc_acc   = crc32_update(crc_acc, d);
            frame_pos = frame_pos + 7'd1;
        end
    endtask

    task automatic predict_report_byte(input report_byte_t rb);
        logic        first;
        int          pad;
        int          room;
        logic [31:0] fcs;
        first      = (byte_idx == 16'd0);
        step_count = 0;
        if (first)
        begin
            drop_rpt = (rb.len > max_len) ||
                       (wl_mode && rb.len < bof_pkg::MIN_WIRELESS_LEN);
            if (wl_mode)
            begin
                crc_acc   = crc32_update(bof_pkg::CRC_INIT, bof_pkg::CRC_SEED_BYTE);
                frame_pos = '0;
            end
        end
        if (!drop_rpt)
        begin
            if (!wl_mode)
                push_tx(rb.data, rb.last);
            else
            begin
                if (first && !kind && rb.data == bof_pkg::ID_OLD_PAD)
                begin
                    frame_byte(bof_pkg::HDR_OLD_B0);
                    frame_byte(bof_pkg::HDR_OLD_B1);
                    frame_byte(bof_pkg::HDR_OLD_B2);
                end
                else if (first && kind && rb.data == bof_pkg::ID_NEW_PAD)
                begin
                    frame_byte(bof_pkg::HDR_NEW_B0);
                    frame_byte({seq_num, 4'h0});
                    frame_byte(bof_pkg::HDR_NEW_B2);
                    seq_num = seq_num + 4'd1;
                end
                else
                    frame_byte(rb.data);
                if (rb.last)
                begin
                    pad = 0;
                    if (int'(frame_pos) < bof_pkg::FRAME_LEN)
                        pad = bof_pkg::FRAME_LEN - int'(frame_pos);
                    room = bof_pkg::MAX_RESULTS - 4 - step_count;
                    // a very short report has its padding cut to the room left for results
                    if (pad > room)
                        pad = room;
                    repeat (pad)
                        frame_byte(8'h00);
                    fcs = ~crc_acc;
                    push_tx(fcs[7:0],   1'b0);
                    push_tx(fcs[15:8],  1'b0);
                    push_tx(fcs[23:16], 1'b0);
                    push_tx(fcs[31:24], 1'b1);
                end
            end
        end
        if (rb.last)
        begin
            byte_idx  = '0;
            drop_rpt  = 1'b0;
            frame_pos = '0;
            crc_acc   = bof_pkg::CRC_INIT;
        end
        else if (byte_idx != 16'hFFFF)
            byte_idx = byte_idx + 16'd1;
    endtask

    // input transactions feed the predictor
    always @(posedge clk)
    begin
        in_fire = rst_n && s_tvalid && s_tready;
        if (in_fire)
            predict_report_byte('{s_tdata[7:0], s_tlast, s_tdata[23:8]});
    end

    // driver: slave side and sink stalls change on the falling edge
    always @(negedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (!s_tvalid || in_fire)
        begin
            if (report_bytes_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT))
            begin
                next_byte = report_bytes_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {next_byte.len, next_byte.data};
                s_tlast  <= next_byte.last;
            end
            else
                s_tvalid <= 1'b0;
        end
        m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (tx_bytes_due.size() == 0)
                report_mismatch($sformatf("unexpected byte %02h last %0b", m_tdata, m_tlast));
            else
            begin
                due_byte = tx_bytes_due.pop_front();
                if (m_tdata !== due_byte.data)
                    report_mismatch($sformatf("out_byte %02h, wanted %02h",
                                              m_tdata, due_byte.data));
                if (m_tlast !== due_byte.frame_end)
                    report_mismatch($sformatf("frame_end %0b, wanted %0b",
                                              m_tlast, due_byte.frame_end));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            report_mismatch($sformatf("timeout with %0d bytes still due",
                                      tx_bytes_due.size()));
            $display("** bt_output_report_framer: FAILED **");
            $finish;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_addr  <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            bof_pkg::REG_WIRELESS: wl_mode = val[0];
            bof_pkg::REG_KIND:     kind    = val[0];
            bof_pkg::REG_MAX_LEN:  max_len = val;
            default:               ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // dropped bytes leave nothing to wait for, so a pause follows the last result
    task automatic wait_drained();
        do
        begin
            @(posedge clk);
            while (report_bytes_q.size() != 0 || s_tvalid || tx_bytes_due.size() != 0)
                @(posedge clk);
            repeat (DRAIN_CYCLES)
                @(posedge clk);
        end
        while (tx_bytes_due.size() != 0);
    endtask

    task automatic queue_report(input logic [7:0] id, input logic [15:0] len,
                                input int nbytes, input bit close);
        report_byte_t rb;
        for (int i = 0; i < nbytes; i++)
        begin
            rb.data = (i == 0) ? id : 8'($urandom_range(255));
            rb.len  = len;
            rb.last = close && (i == nbytes - 1);
            report_bytes_q.insert(report_bytes_q.size(), rb);
        end
        items_queued += nbytes;
    endtask

    // mostly well-formed reports, some with a wild length or an early or late end
    task automatic queue_random_reports(input int budget);
        int         start;
        int         lo;
        int         hi;
        int         len;
        int         nbytes;
        int         pick;
        logic [7:0] id;
        start = items_queued;
        while (items_queued - start < budget)
        begin
            lo = wl_mode ? bof_pkg::MIN_WIRELESS_LEN : 1;
            hi = (max_len < 90) ? int'(max_len) : 90;
            if (hi < lo)
                hi = lo;
            len    = $urandom_range(hi, lo);
            nbytes = len;
            pick   = $urandom_range(99);
            if (pick >= 85)
            begin
                len    = $urandom_range(65535, 1);
                nbytes = $urandom_range(4, 1);
            end
            else if (pick >= 70)
                nbytes = $urandom_range(len + 5, 1);
            case ($urandom_range(3))
                0:       id = bof_pkg::ID_OLD_PAD;
                1:       id = bof_pkg::ID_NEW_PAD;
                default: id = 8'($urandom_range(255));
            endcase
            queue_report(id, 16'(len), nbytes, 1'b1);
        end
    endtask

    initial
    begin
        repeat (3)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // pass-through with reset settings
        queue_report(8'h00, 16'd1, 1, 1'b1);
        queue_report(8'hFF, 16'd78, 2, 1'b1);
        queue_report(8'h5A, 16'd79, 1, 1'b1);
        queue_report(8'hA5, 16'hFFFF, 2, 1'b1);
        queue_random_reports(10);
        // left open so that wireless comes on part way through
        queue_report(8'h33, 16'd5, 3, 1'b0);
        wait_drained();

        write_reg(bof_pkg::REG_WIRELESS, 16'd1);
        queue_report(8'hC3, 16'd5, 2, 1'b1);
        queue_report(bof_pkg::ID_OLD_PAD, 16'd20, 1, 1'b1);
        queue_report(bof_pkg::ID_OLD_PAD, 16'd14, 1, 1'b1);
        queue_report(bof_pkg::ID_OLD_PAD, 16'd15, 15, 1'b1);
        queue_report(8'h7E, 16'd15, 15, 1'b1);
        queue_random_reports(20);
        wait_drained();

        // newer pad type, enough reports to wrap the sequence number
        write_reg(bof_pkg::REG_KIND, 16'd1);
        repeat (18)
            queue_report(bof_pkg::ID_NEW_PAD, 16'd15, 1, 1'b1);
        queue_report(bof_pkg::ID_OLD_PAD, 16'd15, 1, 1'b1);
        queue_random_reports(20);
        wait_drained();

        write_reg(bof_pkg::REG_WIRELESS, 16'd0);
        write_reg(bof_pkg::REG_MAX_LEN, 16'hFFFF);
        queue_random_reports(10);
        wait_drained();

        write_reg(bof_pkg::REG_WIRELESS, 16'd1);
        write_reg(bof_pkg::REG_MAX_LEN, 16'd0);
        queue_random_reports(10);
        wait_drained();

        // reports longer than the frame, with no idling on either side
        write_reg(bof_pkg::REG_MAX_LEN, 16'd100);
        write_reg(bof_pkg::REG_KIND, 16'd0);
        calm = 1'b1;
        queue_random_reports(30);
        wait_drained();
        calm = 1'b0;

        write_reg(bof_pkg::REG_WIRELESS, 16'd0);
        write_reg(bof_pkg::REG_KIND, 16'd1);
        write_reg(bof_pkg::REG_MAX_LEN, 16'd78);
        queue_random_reports(10);
        wait_drained();

        if (fail_count == 0)
            $display("** bt_output_report_framer: PASSED **");
        else
            $display("** bt_output_report_framer: FAILED **");
        $finish;
    end

endmodule

// File: sim.f
rtl/bof_pkg.sv
rtl/bof_ctrl.sv
rtl/bof_datapath.sv
rtl/bt_output_report_framer.sv
bench/tb_bt_output_report_framer.sv
